// ----- rtl/adll_pkg.sv -----
// Shared types and constants for the array doubly linked list block.
// No dependencies; every other file of the block refers to this package.
`default_nettype none
package adll_pkg;
   localparam int SLOTS = 16;
   localparam int DATA_WIDTH = 32;
   localparam int SLOT_W = $clog2(SLOTS);
   localparam int LINK_W = SLOT_W + 1;
   localparam int CNT_W = $clog2(SLOTS + 1);
   localparam int OP_W = 4;
   localparam int STATUS_W = 3;
   localparam int FIELD_W = 32;
   localparam int IDX_W = 4;
   localparam int TOTAL_W = 5;
   localparam logic [LINK_W-1:0] NIL = LINK_W'(SLOTS);

   typedef enum logic [OP_W-1:0] {
      OP_PUSH_HEAD = 4'd0, OP_PUSH_TAIL = 4'd1, OP_POP_HEAD = 4'd2,
      OP_POP_TAIL = 4'd3, OP_FIND = 4'd4, OP_INS_AFTER_VAL = 4'd5,
      OP_INS_BEFORE_VAL = 4'd6, OP_DEL_VAL = 4'd7, OP_INS_AFTER_SLOT = 4'd8,
      OP_INS_BEFORE_SLOT = 4'd9, OP_DEL_SLOT = 4'd10
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK = 3'd0, ST_FULL = 3'd1, ST_EMPTY = 3'd2, ST_NOT_FOUND = 3'd3,
      ST_BAD_SLOT = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE, S_SEARCH, S_EXEC, S_LINK, S_DONE
   } state_type;

   typedef struct packed {
      logic [OP_W-1:0]     op;
      logic [FIELD_W-1:0]  value;
      logic [FIELD_W-1:0]  new_value;
      logic [IDX_W-1:0]    slot_index;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [FIELD_W-1:0]  data_out;
      logic [IDX_W-1:0]    found_slot;
      logic [TOTAL_W-1:0]  item_total;
   } rsp_type;

   // Search unit control: start a walk, and its answer.
   typedef struct packed {
      logic              start;
      logic [LINK_W-1:0] head;
   } walk_cmd_type;

   typedef struct packed {
      logic              busy;
      logic              done;
      logic [LINK_W-1:0] hit;
   } walk_stat_type;

   function automatic logic [DATA_WIDTH-1:0] to_data(logic [FIELD_W-1:0] raw);
      logic [63:0] ext;
      ext = {{32{raw[FIELD_W-1]}}, raw};
      return ext[DATA_WIDTH-1:0];
   endfunction
endpackage
`default_nettype wire

// ----- rtl/adll_if.sv -----
// Valid/ready channel interface carrying one payload type per beat.
// Depends on adll_pkg for payload types.
`default_nettype none
interface adll_req_if;
   logic               valid;
   logic               ready;
   adll_pkg::req_type  payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface adll_rsp_if;
   logic               valid;
   logic               ready;
   adll_pkg::rsp_type  payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ----- rtl/array_doubly_linked_list_top.sv -----
// Top level of the array doubly linked list: sequencer, slot storage and
// the search unit. Depends on adll_pkg, adll_if and adll_walk.
//
// One operation is taken per request beat and answered by one response
// beat. Every operation first runs the search unit from the head. It
// visits one slot per cycle and stops at the first slot holding the
// request value, or at the end of the list. After the walk the sequencer
// passes through S_EXEC and, when the list changes, S_LINK to S_DONE,
// where the response beat is offered. The block does not accept a new
// request until the response beat is taken, and it is ready again in the
// cycle after that.
`default_nettype none
module array_doubly_linked_list_top (
   input  wire logic clock,
   input  wire logic reset,
   adll_req_if.sink  req,
   adll_rsp_if.source rsp
);
   localparam int SW = adll_pkg::SLOT_W;
   localparam int LW = adll_pkg::LINK_W;
   localparam int DW = adll_pkg::DATA_WIDTH;

   adll_pkg::state_type state_ff, state_in;
   adll_pkg::req_type   cmd_ff, cmd_in;
   adll_pkg::rsp_type   out_ff, out_in;

   logic [DW-1:0] val_ff [adll_pkg::SLOTS];
   logic [LW-1:0] nxt_ff [adll_pkg::SLOTS];
   logic [LW-1:0] prv_ff [adll_pkg::SLOTS];
   logic [adll_pkg::SLOTS-1:0] used_ff, used_in;
   logic [LW-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [adll_pkg::CNT_W-1:0] count_ff, count_in;
   logic [LW-1:0] at_ff, at_in;
   logic [LW-1:0] free_slot;

   adll_pkg::walk_cmd_type  wcmd;
   adll_pkg::walk_stat_type wstat;
   logic [SW-1:0] wslot;

   adll_walk u_walk (
      .clock(clock), .reset(reset), .cmd(wcmd),
      .key(adll_pkg::to_data(req.payload.value)),
      .rd_slot(wslot), .rd_value(val_ff[wslot]), .rd_used(used_ff[wslot]),
      .rd_next(nxt_ff[wslot]), .stat(wstat)
   );

   // Lowest free slot, from the valid bits.
   always_comb begin
      free_slot = adll_pkg::NIL;
      for (int i = adll_pkg::SLOTS - 1; i >= 0; i--) begin
         if (!used_ff[i]) free_slot = LW'(i);
      end
   end

   // Link write requests built in S_LINK.
   logic           wr_en;
   logic [SW-1:0]  wr_s;
   logic [DW-1:0]  wr_v;
   logic [LW-1:0]  wr_n, wr_p;
   logic           nx_en, pv_en;
   logic [SW-1:0]  nx_s, pv_s;
   logic [LW-1:0]  nx_d, pv_d;

   logic [adll_pkg::OP_W-1:0] op;
   logic is_push, is_rem, is_ins, is_slot, after;
   logic [SW-1:0] at_s, new_s;
   logic [LW-1:0] at_n, at_p;
   logic [SW-1:0] si;

   assign op = cmd_ff.op;
   assign si = cmd_ff.slot_index[SW-1:0];
   assign at_s = at_ff[SW-1:0];
   assign new_s = free_slot[SW-1:0];
   assign at_n = nxt_ff[at_s];
   assign at_p = prv_ff[at_s];

   always_comb begin
      is_push = op == adll_pkg::OP_PUSH_HEAD || op == adll_pkg::OP_PUSH_TAIL;
      is_rem = op == adll_pkg::OP_POP_HEAD || op == adll_pkg::OP_POP_TAIL ||
               op == adll_pkg::OP_FIND || op == adll_pkg::OP_DEL_VAL ||
               op == adll_pkg::OP_DEL_SLOT;
      is_ins = op == adll_pkg::OP_INS_AFTER_VAL || op == adll_pkg::OP_INS_BEFORE_VAL ||
               op == adll_pkg::OP_INS_AFTER_SLOT || op == adll_pkg::OP_INS_BEFORE_SLOT;
      is_slot = op == adll_pkg::OP_INS_AFTER_SLOT || op == adll_pkg::OP_INS_BEFORE_SLOT ||
                op == adll_pkg::OP_DEL_SLOT;
      after = op == adll_pkg::OP_PUSH_TAIL || op == adll_pkg::OP_INS_AFTER_VAL ||
              op == adll_pkg::OP_INS_AFTER_SLOT;
   end

   always_comb begin
      state_in = state_ff;
      cmd_in = cmd_ff;
      out_in = out_ff;
      used_in = used_ff;
      head_in = head_ff;
      tail_in = tail_ff;
      count_in = count_ff;
      at_in = at_ff;
      wcmd.start = 1'b0;
      wcmd.head = head_ff;
      wr_en = 1'b0; wr_s = new_s; wr_v = '0; wr_n = adll_pkg::NIL; wr_p = adll_pkg::NIL;
      nx_en = 1'b0; nx_s = at_s; nx_d = adll_pkg::NIL;
      pv_en = 1'b0; pv_s = at_s; pv_d = adll_pkg::NIL;
      unique case (state_ff)
         adll_pkg::S_IDLE: begin
            if (req.valid) begin
               cmd_in = req.payload;
               wcmd.start = 1'b1;
               state_in = adll_pkg::S_SEARCH;
            end
         end
         adll_pkg::S_SEARCH: begin
            // The walk always runs; its answer is used by value operations only.
            if (wstat.done) begin
               at_in = wstat.hit;
               state_in = adll_pkg::S_EXEC;
            end
         end
         adll_pkg::S_EXEC: begin
            out_in = '0;
            state_in = adll_pkg::S_DONE;
            if (is_push || is_ins) begin
               if (count_ff >= adll_pkg::CNT_W'(adll_pkg::SLOTS)) begin
                  out_in.status = adll_pkg::ST_FULL;
               end else if (is_push) begin
                  at_in = (op == adll_pkg::OP_PUSH_HEAD) ? head_ff : tail_ff;
                  state_in = adll_pkg::S_LINK;
               end else if (is_slot) begin
                  if (LW'(cmd_ff.slot_index) >= adll_pkg::NIL || !used_ff[si])
                     out_in.status = adll_pkg::ST_BAD_SLOT;
                  else begin
                     at_in = LW'(si);
                     state_in = adll_pkg::S_LINK;
                  end
               end else if (at_ff >= adll_pkg::NIL) begin
                  out_in.status = adll_pkg::ST_NOT_FOUND;
               end else begin
                  state_in = adll_pkg::S_LINK;
               end
            end else if (is_rem) begin
               if (count_ff == '0 || head_ff >= adll_pkg::NIL) begin
                  out_in.status = adll_pkg::ST_EMPTY;
               end else if (op == adll_pkg::OP_POP_HEAD || op == adll_pkg::OP_POP_TAIL) begin
                  at_in = (op == adll_pkg::OP_POP_HEAD) ? head_ff : tail_ff;
                  state_in = adll_pkg::S_LINK;
               end else if (is_slot) begin
                  if (LW'(cmd_ff.slot_index) >= adll_pkg::NIL || !used_ff[si])
                     out_in.status = adll_pkg::ST_BAD_SLOT;
                  else begin
                     at_in = LW'(si);
                     state_in = adll_pkg::S_LINK;
                  end
               end else if (at_ff >= adll_pkg::NIL) begin
                  out_in.status = adll_pkg::ST_NOT_FOUND;
               end else if (op == adll_pkg::OP_FIND) begin
                  out_in.found_slot = adll_pkg::IDX_W'(at_s);
               end else begin
                  state_in = adll_pkg::S_LINK;
               end
            end
            out_in.item_total = adll_pkg::TOTAL_W'(count_ff);
         end
         adll_pkg::S_LINK: begin
            state_in = adll_pkg::S_DONE;
            if (is_push || is_ins) begin
               used_in[new_s] = 1'b1;
               count_in = count_ff + 1'b1;
               wr_en = 1'b1;
               wr_v = adll_pkg::to_data(is_push ? cmd_ff.value : cmd_ff.new_value);
               out_in.found_slot = adll_pkg::IDX_W'(new_s);
               out_in.item_total = adll_pkg::TOTAL_W'(count_ff + 1'b1);
               if (head_ff >= adll_pkg::NIL) begin
                  head_in = free_slot;
                  tail_in = free_slot;
               end else if (after) begin
                  wr_p = at_ff; wr_n = at_n;
                  if (at_n < adll_pkg::NIL) begin
                     pv_en = 1'b1; pv_s = at_n[SW-1:0]; pv_d = free_slot;
                  end else tail_in = free_slot;
                  nx_en = 1'b1; nx_s = at_s; nx_d = free_slot;
               end else begin
                  wr_n = at_ff; wr_p = at_p;
                  if (at_p < adll_pkg::NIL) begin
                     nx_en = 1'b1; nx_s = at_p[SW-1:0]; nx_d = free_slot;
                  end else head_in = free_slot;
                  pv_en = 1'b1; pv_s = at_s; pv_d = free_slot;
               end
            end else begin
               if (at_p < adll_pkg::NIL) begin
                  nx_en = 1'b1; nx_s = at_p[SW-1:0]; nx_d = at_n;
               end else head_in = at_n;
               if (at_n < adll_pkg::NIL) begin
                  pv_en = 1'b1; pv_s = at_n[SW-1:0]; pv_d = at_p;
               end else tail_in = at_p;
               used_in[at_s] = 1'b0;
               count_in = count_ff - 1'b1;
               out_in.item_total = adll_pkg::TOTAL_W'(count_ff - 1'b1);
               if (op == adll_pkg::OP_POP_HEAD || op == adll_pkg::OP_POP_TAIL)
                  out_in.data_out = adll_pkg::FIELD_W'(val_ff[at_s]);
            end
         end
         adll_pkg::S_DONE: begin
            if (rsp.ready) state_in = adll_pkg::S_IDLE;
         end
         default: state_in = adll_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= adll_pkg::S_IDLE;
         used_ff <= '0;
         head_ff <= adll_pkg::NIL;
         tail_ff <= adll_pkg::NIL;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         used_ff <= used_in;
         head_ff <= head_in;
         tail_ff <= tail_in;
         count_ff <= count_in;
      end
      cmd_ff <= cmd_in;
      out_ff <= out_in;
      at_ff <= at_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         val_ff[wr_s] <= wr_v;
         nxt_ff[wr_s] <= wr_n;
         prv_ff[wr_s] <= wr_p;
      end
      if (nx_en) nxt_ff[nx_s] <= nx_d;
      if (pv_en) prv_ff[pv_s] <= pv_d;
   end

   assign req.ready = state_ff == adll_pkg::S_IDLE;
   assign rsp.valid = state_ff == adll_pkg::S_DONE;
   assign rsp.payload = out_ff;

`ifndef NO_ASSERTIONS
   a_count_bits: assert property (@(posedge clock) disable iff (reset)
      $countones(used_ff) == int'(count_ff))
      else $error("item count differs from used slots");
   a_empty_head: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (head_ff == adll_pkg::NIL && tail_ff == adll_pkg::NIL))
      else $error("empty list with live head or tail");
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req.ready && rsp.valid))
      else $error("request taken while response pending");
`endif
endmodule
`default_nettype wire

// ----- rtl/adll_walk.sv -----
// Search sequencer: walks the list from the head, one link per cycle,
// comparing each slot against the key. Depends on adll_pkg.
`default_nettype none
module adll_walk (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire adll_pkg::walk_cmd_type             cmd,
   input  wire logic [adll_pkg::DATA_WIDTH-1:0]    key,
   output logic [adll_pkg::SLOT_W-1:0]             rd_slot,
   input  wire logic [adll_pkg::DATA_WIDTH-1:0]    rd_value,
   input  wire logic                               rd_used,
   input  wire logic [adll_pkg::LINK_W-1:0]        rd_next,
   output adll_pkg::walk_stat_type                 stat
);
   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [adll_pkg::LINK_W-1:0]     cur_ff, cur_in;
   logic [adll_pkg::LINK_W-1:0]     hit_ff, hit_in;
   logic [adll_pkg::CNT_W-1:0]      steps_ff, steps_in;
   logic [adll_pkg::DATA_WIDTH-1:0] key_ff, key_in;

   assign rd_slot = cur_ff[adll_pkg::SLOT_W-1:0];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cur_in = cur_ff;
      hit_in = hit_ff;
      steps_in = steps_ff;
      key_in = key_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         cur_in = cmd.head;
         steps_in = '0;
         key_in = key;
         hit_in = adll_pkg::NIL;
      end else if (busy_ff) begin
         // One compare and one link step per cycle.
         if (cur_ff >= adll_pkg::NIL || steps_ff == adll_pkg::CNT_W'(adll_pkg::SLOTS)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else if (rd_used && rd_value == key_ff) begin
            hit_in = cur_ff;
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cur_in = rd_next;
            steps_in = steps_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cur_ff <= cur_in;
      hit_ff <= hit_in;
      steps_ff <= steps_in;
      key_ff <= key_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign stat.hit = hit_ff;
endmodule
`default_nettype wire
